// ----- hw/rtl/pmrf_pkg.sv -----
// ----------------------------------------------------------------------------
// pmrf_pkg
// Types and constants shared by the panel meter range formatter modules.
// ----------------------------------------------------------------------------
package pmrf_pkg;

    localparam int ADC_W       = 8;
    localparam int STEP_W      = 12;
    localparam int BIAS_W      = 19;
    localparam int PROD_W      = 20;
    localparam int BCD_DIGITS  = 7;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int DD_STAGES   = 5;
    localparam int DD_BITS     = 4;
    localparam int SEQ_LEN     = 9;
    localparam int SEQ_W       = 4;

    localparam logic [BIAS_W-1:0] BIAS_RST    = 19'd200000;
    localparam logic [STEP_W-1:0] STEP_RST    = 12'd1953;
    localparam logic [PROD_W-1:0] MV_POS_SPAN = 20'd25000;
    localparam logic [PROD_W-1:0] MV_NEG_SPAN = 20'd15000;
    localparam logic [PROD_W-1:0] V_SPAN      = 20'd200000;

    localparam logic CFG_BIAS_LEVEL = 1'b0;
    localparam logic CFG_LSB_STEP   = 1'b1;

    localparam logic [7:0] CHR_HOME  = 8'h80;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_POINT = 8'h2E;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_E     = 8'h45;
    localparam logic [7:0] CHR_R     = 8'h52;
    localparam logic [7:0] CHR_O     = 8'h4F;
    localparam logic [7:0] CHR_M     = 8'h6D;
    localparam logic [7:0] CHR_V     = 8'h56;

    typedef enum logic [1:0] {
        RANGE_200MV = 2'd0,
        RANGE_2V    = 2'd1,
        RANGE_20V   = 2'd2,
        RANGE_200V  = 2'd3
    } range_t;

    // dig[3] is the leading digit
    typedef struct packed {
        logic             ok;
        logic             neg;
        range_t           mode;
        logic [3:0][3:0]  dig;
    } job_t;

endpackage

// ----- hw/rtl/panel_meter_range_formatter.sv -----
// ----------------------------------------------------------------------------
// panel_meter_range_formatter
// Panel meter display formatter: range button handling, sample scaling,
// window check and decimal byte stream for a character display.
//
//   channel   direction  fields
//   s_axis    in         tuser: cmd; tdata: adc_code
//   m_axis    out        tuser: is_command; tdata: char_byte; tlast: last
//   cfg       in         index 0 bias_level, index 1 lsb_step
//
// a range press is taken and emits nothing
// a sample passes a 7-stage conversion pipeline, then a job queue
// the byte sequencer emits 6 (error) or 8-9 items per sample, one per cycle
// while m_axis is ready
// m_axis stalls fill the queue; the input stalls only when the queue is full
// reset clears range to 200mV, registers to their defaults; no clearing pass
// ----------------------------------------------------------------------------
module panel_meter_range_formatter
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [pmrf_pkg::BIAS_W-1:0] cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // adc_code
    input  logic                        s_axis_tuser,  // cmd
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // char_byte
    output logic                        m_axis_tuser,  // is_command
    output logic                        m_axis_tlast
);
    import pmrf_pkg::*;

    job_t  push_job;
    job_t  head_job;
    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;

    pmrf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_code    (s_axis_tdata),
        .queue_full (full),
        .job_valid  (push),
        .job        (push_job)
    );

    pmrf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head_job)
    );

    pmrf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (head_valid),
        .job        (head_job),
        .job_pop    (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

// ----- hw/rtl/pmrf_front.sv -----
// ----------------------------------------------------------------------------
// pmrf_front
// Accepts items, tracks the range, scales and window-checks each sample and
// converts the magnitude to decimal in a stalling pipeline.
// ----------------------------------------------------------------------------
module pmrf_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [pmrf_pkg::BIAS_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_cmd,
    input  logic [pmrf_pkg::ADC_W-1:0] in_code,
    input  logic                       queue_full,
    output logic                       job_valid,
    output pmrf_pkg::job_t             job
);
    import pmrf_pkg::*;

    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                                 input logic bit_in);
        logic [BCD_W-1:0] t;
        t = b;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (t[4*i +: 4] >= 4'd5)
            begin
                t[4*i +: 4] = t[4*i +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

    range_t              mode_reg, mode_next;
    logic [BIAS_W-1:0]   bias_reg, bias_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic                s1_vld_reg, s1_vld_next;
    range_t              s1_mode_reg, s1_mode_next;
    logic [PROD_W-1:0]   s1_prod_reg, s1_prod_next;

    logic                s2_vld_reg, s2_vld_next;
    range_t              s2_mode_reg, s2_mode_next;
    logic                s2_ok_reg, s2_ok_next;
    logic                s2_neg_reg, s2_neg_next;
    logic [PROD_W-1:0]   s2_mag_reg, s2_mag_next;

    logic                dd_vld_reg  [DD_STAGES];
    logic                dd_vld_next [DD_STAGES];
    range_t              dd_mode_reg [DD_STAGES];
    range_t              dd_mode_next[DD_STAGES];
    logic                dd_ok_reg   [DD_STAGES];
    logic                dd_ok_next  [DD_STAGES];
    logic                dd_neg_reg  [DD_STAGES];
    logic                dd_neg_next [DD_STAGES];
    logic [BCD_W-1:0]    dd_bcd_reg  [DD_STAGES];
    logic [BCD_W-1:0]    dd_bcd_next [DD_STAGES];
    logic [PROD_W-1:0]   dd_rest_reg [DD_STAGES];
    logic [PROD_W-1:0]   dd_rest_next[DD_STAGES];

    logic                adv;
    logic                take;
    logic [PROD_W:0]     diff;
    logic [PROD_W:0]     diff_neg;
    logic                neg;
    logic [PROD_W-1:0]   mag;
    logic                ok;
    logic [BCD_W-1:0]    out_bcd;

    assign adv      = !(dd_vld_reg[DD_STAGES-1] && queue_full);
    assign take     = in_valid && adv;
    assign in_ready = adv;

    always_comb
    begin
        mode_next = mode_reg;
        bias_next = bias_reg;
        step_next = step_reg;
        if (take && in_cmd)
        begin
            mode_next = range_t'(mode_reg + 2'd1);
        end
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIAS_LEVEL: bias_next = cfg_data;
                CFG_LSB_STEP:   step_next = cfg_data[STEP_W-1:0];
                default:        bias_next = bias_reg;
            endcase
        end
    end

    // stage 1: scale
    always_comb
    begin
        s1_vld_next  = adv ? (take && !in_cmd) : s1_vld_reg;
        s1_mode_next = adv ? mode_reg : s1_mode_reg;
        s1_prod_next = adv ? PROD_W'(in_code) * PROD_W'(step_reg) : s1_prod_reg;
    end

    // stage 2: remove bias, window check
    always_comb
    begin
        diff     = {1'b0, s1_prod_reg} - (PROD_W + 1)'(bias_reg);
        diff_neg = -diff;
        neg      = diff[PROD_W];
        mag      = neg ? diff_neg[PROD_W-1:0] : diff[PROD_W-1:0];
        case (s1_mode_reg)
            RANGE_200MV: ok = neg ? (mag <= MV_NEG_SPAN) : (mag <= MV_POS_SPAN);
            RANGE_2V:    ok = neg ? 1'b1 : (mag < V_SPAN);
            default:     ok = neg ? (mag <= V_SPAN) : (mag < V_SPAN);
        endcase
        s2_vld_next  = adv ? s1_vld_reg  : s2_vld_reg;
        s2_mode_next = adv ? s1_mode_reg : s2_mode_reg;
        s2_ok_next   = adv ? ok          : s2_ok_reg;
        s2_neg_next  = adv ? neg         : s2_neg_reg;
        s2_mag_next  = adv ? mag         : s2_mag_reg;
    end

    // binary to decimal, four bits per stage
    always_comb
    begin
        logic [BCD_W-1:0]  b;
        logic [PROD_W-1:0] r;
        for (int g = 0; g < DD_STAGES; g++)
        begin
            if (g == 0)
            begin
                b = '0;
                r = s2_mag_reg;
            end
            else
            begin
                b = dd_bcd_reg[g-1];
                r = dd_rest_reg[g-1];
            end
            for (int k = 0; k < DD_BITS; k++)
            begin
                b = dabble(b, r[PROD_W-1]);
                r = {r[PROD_W-2:0], 1'b0};
            end
            if (!adv)
            begin
                dd_vld_next[g]  = dd_vld_reg[g];
                dd_mode_next[g] = dd_mode_reg[g];
                dd_ok_next[g]   = dd_ok_reg[g];
                dd_neg_next[g]  = dd_neg_reg[g];
                dd_bcd_next[g]  = dd_bcd_reg[g];
                dd_rest_next[g] = dd_rest_reg[g];
            end
            else if (g == 0)
            begin
                dd_vld_next[g]  = s2_vld_reg;
                dd_mode_next[g] = s2_mode_reg;
                dd_ok_next[g]   = s2_ok_reg;
                dd_neg_next[g]  = s2_neg_reg;
                dd_bcd_next[g]  = b;
                dd_rest_next[g] = r;
            end
            else
            begin
                dd_vld_next[g]  = dd_vld_reg[g-1];
                dd_mode_next[g] = dd_mode_reg[g-1];
                dd_ok_next[g]   = dd_ok_reg[g-1];
                dd_neg_next[g]  = dd_neg_reg[g-1];
                dd_bcd_next[g]  = b;
                dd_rest_next[g] = r;
            end
        end
    end

    always_comb
    begin
        out_bcd   = dd_bcd_reg[DD_STAGES-1];
        job.ok    = dd_ok_reg[DD_STAGES-1];
        job.neg   = dd_neg_reg[DD_STAGES-1];
        job.mode  = dd_mode_reg[DD_STAGES-1];
        if (dd_mode_reg[DD_STAGES-1] == RANGE_200MV)
        begin
            job.dig = {out_bcd[19:16], out_bcd[15:12], out_bcd[11:8], out_bcd[7:4]};
        end
        else
        begin
            job.dig = {out_bcd[23:20], out_bcd[19:16], out_bcd[15:12], out_bcd[11:8]};
        end
        job_valid = dd_vld_reg[DD_STAGES-1] && !queue_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RANGE_200MV;
            bias_reg   <= BIAS_RST;
            step_reg   <= STEP_RST;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            for (int g = 0; g < DD_STAGES; g++)
            begin
                dd_vld_reg[g] <= 1'b0;
            end
        end
        else
        begin
            mode_reg   <= mode_next;
            bias_reg   <= bias_next;
            step_reg   <= step_next;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            for (int g = 0; g < DD_STAGES; g++)
            begin
                dd_vld_reg[g] <= dd_vld_next[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= s1_mode_next;
        s1_prod_reg <= s1_prod_next;
        s2_mode_reg <= s2_mode_next;
        s2_ok_reg   <= s2_ok_next;
        s2_neg_reg  <= s2_neg_next;
        s2_mag_reg  <= s2_mag_next;
        for (int g = 0; g < DD_STAGES; g++)
        begin
            dd_mode_reg[g] <= dd_mode_next[g];
            dd_ok_reg[g]   <= dd_ok_next[g];
            dd_neg_reg[g]  <= dd_neg_next[g];
            dd_bcd_reg[g]  <= dd_bcd_next[g];
            dd_rest_reg[g] <= dd_rest_next[g];
        end
    end

endmodule

// ----- hw/rtl/pmrf_fifo.sv -----
// ----------------------------------------------------------------------------
// pmrf_fifo
// Short job queue between the conversion pipeline and the byte sequencer.
// ----------------------------------------------------------------------------
module pmrf_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pmrf_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output pmrf_pkg::job_t head
);
    import pmrf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ on empty queue");
`endif

endmodule

// ----- hw/rtl/pmrf_back.sv -----
// ----------------------------------------------------------------------------
// pmrf_back
// Byte sequencer: expands one job into its display run, one item per cycle
// while the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module pmrf_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  pmrf_pkg::job_t job,
    output logic           job_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_data,
    output logic           out_user,
    output logic           out_last
);
    import pmrf_pkg::*;

    logic [7:0]        seq [SEQ_LEN];
    logic [7:0]        asc [4];
    logic [SEQ_W-1:0]  last_idx;
    logic [SEQ_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [7:0]        data_reg, data_next;
    logic              user_reg, user_next;
    logic              last_reg, last_next;
    logic              load;
    logic              is_last;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            asc[i] = CHR_ZERO | {4'h0, job.dig[i]};
        end
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            seq[i] = CHR_V;
        end
        seq[0] = CHR_HOME;
        if (!job.ok)
        begin
            seq[1]   = CHR_E;
            seq[2]   = CHR_R;
            seq[3]   = CHR_R;
            seq[4]   = CHR_O;
            seq[5]   = CHR_R;
            last_idx = SEQ_W'(5);
        end
        else
        begin
            seq[1]   = job.neg ? CHR_MINUS : CHR_PLUS;
            last_idx = SEQ_W'(7);
            case (job.mode)
                RANGE_200MV:
                begin
                    seq[2]   = asc[3];
                    seq[3]   = asc[2];
                    seq[4]   = asc[1];
                    seq[5]   = CHR_POINT;
                    seq[6]   = asc[0];
                    seq[7]   = CHR_M;
                    last_idx = SEQ_W'(8);
                end
                RANGE_2V:
                begin
                    seq[2] = asc[3];
                    seq[3] = CHR_POINT;
                    seq[4] = asc[2];
                    seq[5] = asc[1];
                    seq[6] = asc[0];
                end
                RANGE_20V:
                begin
                    seq[2] = asc[3];
                    seq[3] = asc[2];
                    seq[4] = CHR_POINT;
                    seq[5] = asc[1];
                    seq[6] = asc[0];
                end
                default:
                begin
                    seq[2] = asc[3];
                    seq[3] = asc[2];
                    seq[4] = asc[1];
                    seq[5] = CHR_POINT;
                    seq[6] = asc[0];
                end
            endcase
        end
    end

    assign load    = job_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == last_idx);
    assign job_pop = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load)
        begin
            idx_next   = is_last ? '0 : idx_reg + SEQ_W'(1);
            valid_next = 1'b1;
            data_next  = seq[idx_reg];
            user_next  = (idx_reg == '0);
            last_next  = is_last;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

endmodule
